[rtl/vnsl_pkg.sv]
// ----------------------------------------------------------------------------
// vnsl_pkg
// Types and codes shared by the nearest-seed label block: item layouts,
// operation and status codes, controller states and the control/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package vnsl_pkg;

  localparam int COORD_W    = 12;
  localparam int OUT_IDX_W  = 6;
  localparam int OUT_DIST_W = 25;

  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [OUT_IDX_W-1:0]  idx_out_t;
  typedef logic [OUT_DIST_W-1:0] dist_t;
  typedef logic [1:0]            code_t;

  // operation codes, code 3 is ignored
  localparam code_t OP_CLEAR   = 2'd0;
  localparam code_t OP_APPEND  = 2'd1;
  localparam code_t OP_QUERY   = 2'd2;
  localparam code_t OP_IGNORED = 2'd3;

  // result status codes
  localparam code_t ST_OK    = 2'd0;
  localparam code_t ST_FULL  = 2'd1;
  localparam code_t ST_EMPTY = 2'd2;

  typedef struct packed {
    code_t  operation;
    coord_t coord_x;
    coord_t coord_y;
  } in_item_t;

  typedef struct packed {
    code_t    status;
    idx_out_t seed_index;
    dist_t    distance_sq;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic  clear_seeds;
    logic  write_seed;
    logic  load_query;
    logic  scan_en;
    logic  reply_load;
    logic  reply_best;
    code_t reply_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last;
    logic pipe_idle;
  } dp_status_t;

endpackage

[rtl/vnsl_ctrl.sv]
// ----------------------------------------------------------------------------
// vnsl_ctrl
// Controller: decodes an accepted item, sequences the seed scan of a query,
// waits for the distance pipeline to empty and strobes the result.
// ----------------------------------------------------------------------------
module vnsl_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  vnsl_pkg::code_t        operation,
  input  vnsl_pkg::dp_status_t   stat,
  output vnsl_pkg::ctrl_cmd_t    ctrl,
  output logic                   busy,
  output logic                   done
);

  vnsl_pkg::state_t state;
  vnsl_pkg::state_t state_next;
  logic             accept;

  assign accept = start && (state == vnsl_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vnsl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      vnsl_pkg::S_IDLE: begin
        if (accept) begin
          if (operation == vnsl_pkg::OP_QUERY && !stat.empty) begin
            state_next = vnsl_pkg::S_SCAN;
          end else begin
            state_next = vnsl_pkg::S_REPLY;
          end
        end
      end
      vnsl_pkg::S_SCAN: begin
        if (stat.scan_last) begin
          state_next = vnsl_pkg::S_DRAIN;
        end
      end
      vnsl_pkg::S_DRAIN: begin
        if (stat.pipe_idle) begin
          state_next = vnsl_pkg::S_REPLY;
        end
      end
      vnsl_pkg::S_REPLY: begin
        state_next = vnsl_pkg::S_IDLE;
      end
      default: begin
        state_next = vnsl_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.reply_status = vnsl_pkg::ST_OK;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      vnsl_pkg::S_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          ctrl.clear_seeds = (operation == vnsl_pkg::OP_CLEAR);
          ctrl.write_seed  = (operation == vnsl_pkg::OP_APPEND) && !stat.full;
          ctrl.load_query  = (operation == vnsl_pkg::OP_QUERY) && !stat.empty;
          ctrl.reply_load  = !ctrl.load_query;
          if (operation == vnsl_pkg::OP_APPEND && stat.full) begin
            ctrl.reply_status = vnsl_pkg::ST_FULL;
          end else if (operation == vnsl_pkg::OP_QUERY && stat.empty) begin
            ctrl.reply_status = vnsl_pkg::ST_EMPTY;
          end
        end
      end
      vnsl_pkg::S_SCAN: begin
        ctrl.scan_en = 1'b1;
      end
      vnsl_pkg::S_DRAIN: begin
        if (stat.pipe_idle) begin
          ctrl.reply_load = 1'b1;
          ctrl.reply_best = 1'b1;
        end
      end
      vnsl_pkg::S_REPLY: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[rtl/vnsl_dpath.sv]
// ----------------------------------------------------------------------------
// vnsl_dpath
// Datapath: seed memory and count, query coordinates, a three-stage
// distance pipeline (read, abs difference, square) and the running minimum.
// ----------------------------------------------------------------------------
module vnsl_dpath #(
  parameter int MAX_SEEDS  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  vnsl_pkg::in_item_t    cmd,
  input  vnsl_pkg::ctrl_cmd_t   ctrl,
  output vnsl_pkg::dp_status_t  stat,
  output vnsl_pkg::out_item_t   result
);

  localparam int IDXW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CNTW = $clog2(MAX_SEEDS + 1);
  localparam int SQW  = 2 * COORD_BITS;
  localparam int DW   = SQW + 1;

  logic [2*COORD_BITS-1:0] seed_mem [MAX_SEEDS];
  logic [CNTW-1:0]         seed_count;
  logic [IDXW-1:0]         scan_addr;
  logic [COORD_BITS-1:0]   qx;
  logic [COORD_BITS-1:0]   qy;

  logic [2*COORD_BITS-1:0] rd_data;
  logic                    rd_valid;
  logic [IDXW-1:0]         rd_idx;
  logic [COORD_BITS-1:0]   rd_x;
  logic [COORD_BITS-1:0]   rd_y;

  logic [COORD_BITS-1:0]   dx;
  logic [COORD_BITS-1:0]   dy;
  logic                    diff_valid;
  logic [IDXW-1:0]         diff_idx;

  logic [SQW-1:0]          sqx;
  logic [SQW-1:0]          sqy;
  logic                    sq_valid;
  logic [IDXW-1:0]         sq_idx;

  logic [DW-1:0]           sum;
  logic [DW-1:0]           best_d;
  logic [IDXW-1:0]         best_i;
  logic                    best_valid;
  vnsl_pkg::dist_t         best_d_out;

  // seed table
  always_ff @(posedge clk) begin
    if (ctrl.write_seed) begin
      seed_mem[seed_count[IDXW-1:0]] <= {COORD_BITS'(cmd.coord_x), COORD_BITS'(cmd.coord_y)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_count <= '0;
    end else if (ctrl.clear_seeds) begin
      seed_count <= '0;
    end else if (ctrl.write_seed) begin
      seed_count <= seed_count + CNTW'(1);
    end
  end

  // query coordinates and scan address
  always_ff @(posedge clk) begin
    if (ctrl.load_query) begin
      qx        <= COORD_BITS'(cmd.coord_x);
      qy        <= COORD_BITS'(cmd.coord_y);
      scan_addr <= '0;
    end else if (ctrl.scan_en) begin
      scan_addr <= scan_addr + IDXW'(1);
    end
  end

  // stage 1: registered memory read
  always_ff @(posedge clk) begin
    if (ctrl.scan_en) begin
      rd_data <= seed_mem[scan_addr];
    end
    rd_idx <= scan_addr;
  end

  assign rd_x = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign rd_y = rd_data[COORD_BITS-1:0];

  // stage 2: absolute differences; stage 3: squares
  always_ff @(posedge clk) begin
    dx       <= (rd_x >= qx) ? (rd_x - qx) : (qx - rd_x);
    dy       <= (rd_y >= qy) ? (rd_y - qy) : (qy - rd_y);
    diff_idx <= rd_idx;
    sqx      <= SQW'(dx) * SQW'(dx);
    sqy      <= SQW'(dy) * SQW'(dy);
    sq_idx   <= diff_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      diff_valid <= 1'b0;
      sq_valid   <= 1'b0;
    end else begin
      rd_valid   <= ctrl.scan_en;
      diff_valid <= rd_valid;
      sq_valid   <= diff_valid;
    end
  end

  assign sum = DW'(sqx) + DW'(sqy);

  // running minimum, strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
    end else if (ctrl.load_query) begin
      best_valid <= 1'b0;
    end else if (sq_valid) begin
      best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_valid && (!best_valid || sum < best_d)) begin
      best_d <= sum;
      best_i <= sq_idx;
    end
  end

  generate
    if (DW > vnsl_pkg::OUT_DIST_W) begin : g_sat
      assign best_d_out = (|best_d[DW-1:vnsl_pkg::OUT_DIST_W]) ? '1
                                                               : vnsl_pkg::dist_t'(best_d);
    end else begin : g_ext
      assign best_d_out = vnsl_pkg::dist_t'(best_d);
    end
  endgenerate

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.reply_load) begin
      if (ctrl.reply_best) begin
        result.status      <= vnsl_pkg::ST_OK;
        result.seed_index  <= vnsl_pkg::idx_out_t'(best_i);
        result.distance_sq <= best_d_out;
      end else begin
        result.status      <= ctrl.reply_status;
        result.seed_index  <= '0;
        result.distance_sq <= '0;
      end
    end
  end

  assign stat.full      = (seed_count == CNTW'(MAX_SEEDS));
  assign stat.empty     = (seed_count == '0);
  assign stat.scan_last = (CNTW'(scan_addr) == seed_count - CNTW'(1));
  assign stat.pipe_idle = !(rd_valid || diff_valid || sq_valid);

endmodule

[rtl/voronoi_nearest_seed_label.sv]
// ----------------------------------------------------------------------------
// voronoi_nearest_seed_label
// Nearest-seed labelling: clear the seed table, append a seed, or query a
// pixel for the nearest seed by squared distance (lowest index on ties).
// ----------------------------------------------------------------------------
// clear, append, ignored and empty-table items strobe done in the cycle after accept
// query with N seeds: after accept, one seed is read from the memory port per cycle,
//   then the 3-stage distance pipeline drains and done strobes
// next item can be taken in the cycle after done
// reset: controller idle, seed table empty; seed memory contents are not cleared
// ----------------------------------------------------------------------------
module voronoi_nearest_seed_label #(
  parameter int MAX_SEEDS  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  vnsl_pkg::in_item_t   cmd,
  output logic                 done,
  output vnsl_pkg::out_item_t  result
);

  vnsl_pkg::ctrl_cmd_t  ctrl;
  vnsl_pkg::dp_status_t stat;

  vnsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (cmd.operation),
    .stat      (stat),
    .ctrl      (ctrl),
    .busy      (busy),
    .done      (done)
  );

  vnsl_dpath #(
    .MAX_SEEDS  (MAX_SEEDS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .ctrl   (ctrl),
    .stat   (stat),
    .result (result)
  );

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_status_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == vnsl_pkg::ST_EMPTY || result.status == vnsl_pkg::ST_FULL))
      |-> (result.seed_index == '0 && result.distance_sq == '0))
    else $error("nonzero fields on a non-ok result");

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (rst)
    (ctrl.write_seed || ctrl.clear_seeds) |-> !busy)
    else $error("seed table changed during a query");

endmodule

[verif/voronoi_nearest_seed_label_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voronoi_nearest_seed_label_tb
// Self-checking bench for the nearest-seed label block. Directed items cover
// empty, tied, extreme and ignored cases. Random clear/append/query sequences
// then fill the seed table to various depths, including past full. A
// scoreboard predicts every result and checks each done strobe in order.
// ----------------------------------------------------------------------------
module voronoi_nearest_seed_label_tb;

  localparam int SEED_CAP     = 64;
  localparam int COORD_TOP    = (1 << vnsl_pkg::COORD_W) - 1;
  localparam int RANDOM_ITEMS = 1300;
  localparam int TAIL_CYCLES  = SEED_CAP + 20;

  class nearest_seed_scoreboard;
    vnsl_pkg::coord_t    seed_x[SEED_CAP];
    vnsl_pkg::coord_t    seed_y[SEED_CAP];
    int unsigned         seed_count;
    vnsl_pkg::out_item_t pending_labels[$];
    int unsigned         fail_count;

    function new();
      seed_count = 0;
      fail_count = 0;
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      fail_count++;
    endtask

    // predict the result of one accepted item and update the seed table
    function void note_item(vnsl_pkg::in_item_t it);
      vnsl_pkg::out_item_t lbl;
      longint unsigned     best_d;
      longint unsigned     d;
      longint unsigned     dx;
      longint unsigned     dy;
      int unsigned         best_i;
      lbl = '0;
      case (it.operation)
        vnsl_pkg::OP_CLEAR: seed_count = 0;
        vnsl_pkg::OP_APPEND: begin
          if (seed_count >= SEED_CAP) begin
            lbl.status = vnsl_pkg::ST_FULL;
          end else begin
            seed_x[seed_count] = it.coord_x;
            seed_y[seed_count] = it.coord_y;
            seed_count++;
          end
        end
        vnsl_pkg::OP_QUERY: begin
          if (seed_count == 0) begin
            lbl.status = vnsl_pkg::ST_EMPTY;
          end else begin
            best_d = 0;
            best_i = 0;
            for (int i = 0; i < seed_count; i++) begin
              dx = (seed_x[i] > it.coord_x) ? seed_x[i] - it.coord_x : it.coord_x - seed_x[i];
              dy = (seed_y[i] > it.coord_y) ? seed_y[i] - it.coord_y : it.coord_y - seed_y[i];
              d = dx * dx + dy * dy;
              // strict compare keeps the lowest index on ties
              if (i == 0 || d < best_d) begin
                best_d = d;
                best_i = i;
              end
            end
            lbl.seed_index = vnsl_pkg::idx_out_t'(best_i);
            lbl.distance_sq = (best_d > {vnsl_pkg::OUT_DIST_W{1'b1}}) ? '1
                                                                     : vnsl_pkg::dist_t'(best_d);
          end
        end
        default: ;
      endcase
      pending_labels = {pending_labels, lbl};
    endfunction

    task check_label(vnsl_pkg::out_item_t got);
      vnsl_pkg::out_item_t want;
      if (pending_labels.size() == 0) begin
        report_mismatch("unexpected result, status", got.status, 0);
      end else begin
        want = pending_labels.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.seed_index !== want.seed_index)
          report_mismatch("seed_index", got.seed_index, want.seed_index);
        if (got.distance_sq !== want.distance_sq)
          report_mismatch("distance_sq", got.distance_sq, want.distance_sq);
      end
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  vnsl_pkg::in_item_t  cmd;
  logic                done;
  vnsl_pkg::out_item_t result;

  nearest_seed_scoreboard label_sb;
  int unsigned            items_sent;
  bit                     no_idle;

  voronoi_nearest_seed_label u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("voronoi_nearest_seed_label_tb NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) label_sb.check_label(result);
  end

  function automatic vnsl_pkg::in_item_t make_cmd(vnsl_pkg::code_t op, vnsl_pkg::coord_t x,
                                                  vnsl_pkg::coord_t y);
    vnsl_pkg::in_item_t it;
    it.operation = op;
    it.coord_x = x;
    it.coord_y = y;
    return it;
  endfunction

  function automatic vnsl_pkg::coord_t pick_coord(bit clustered, vnsl_pkg::coord_t base);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return vnsl_pkg::coord_t'(COORD_TOP);
    if (clustered) return base + vnsl_pkg::coord_t'($urandom_range(7));
    return vnsl_pkg::coord_t'($urandom_range(COORD_TOP));
  endfunction

  task automatic idle_for(int unsigned cycles);
    @(negedge clk);
    start <= 1'b0;
    cmd <= vnsl_pkg::in_item_t'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  // hold the item until the block takes it, then maybe leave a gap
  task automatic send_item(vnsl_pkg::in_item_t it);
    @(negedge clk);
    start <= 1'b1;
    cmd <= it;
    do @(posedge clk); while (busy);
    label_sb.note_item(it);
    items_sent++;
    if (!no_idle && $urandom_range(99) < 6) idle_for($urandom_range(1, 8));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (label_sb.pending_labels.size() != 0) @(posedge clk);
  endtask

  task automatic send_query(bit clustered, vnsl_pkg::coord_t bx, vnsl_pkg::coord_t by);
    int unsigned k;
    if (label_sb.seed_count > 0 && $urandom_range(99) < 30) begin
      // land on or right next to a stored seed
      k = $urandom_range(label_sb.seed_count - 1);
      send_item(make_cmd(vnsl_pkg::OP_QUERY,
                         label_sb.seed_x[k] + vnsl_pkg::coord_t'($urandom_range(2))
                           - vnsl_pkg::coord_t'(1),
                         label_sb.seed_y[k] + vnsl_pkg::coord_t'($urandom_range(2))
                           - vnsl_pkg::coord_t'(1)));
    end else begin
      send_item(make_cmd(vnsl_pkg::OP_QUERY, pick_coord(clustered, bx),
                         pick_coord(clustered, by)));
    end
  endtask

  task automatic maybe_noise();
    if ($urandom_range(99) < 4) send_item(vnsl_pkg::in_item_t'($urandom));
  endtask

  task automatic run_sequence();
    int unsigned      n_seeds;
    int unsigned      n_queries;
    bit               clustered;
    vnsl_pkg::coord_t bx;
    vnsl_pkg::coord_t by;
    n_seeds = ($urandom_range(99) < 12) ? $urandom_range(60, 70) : $urandom_range(1, 12);
    clustered = ($urandom_range(99) < 25);
    bx = vnsl_pkg::coord_t'($urandom_range(COORD_TOP - 7));
    by = vnsl_pkg::coord_t'($urandom_range(COORD_TOP - 7));
    send_item(make_cmd(vnsl_pkg::OP_CLEAR, vnsl_pkg::coord_t'($urandom),
                       vnsl_pkg::coord_t'($urandom)));
    if ($urandom_range(99) < 20) send_query(clustered, bx, by);
    for (int i = 0; i < n_seeds; i++) begin
      send_item(make_cmd(vnsl_pkg::OP_APPEND, pick_coord(clustered, bx),
                         pick_coord(clustered, by)));
      if ($urandom_range(99) < 30) send_query(clustered, bx, by);
      maybe_noise();
    end
    n_queries = $urandom_range(2, 10);
    for (int i = 0; i < n_queries; i++) begin
      send_query(clustered, bx, by);
      maybe_noise();
    end
  endtask

  initial begin
    label_sb = new();
    items_sent = 0;
    no_idle = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, ignored code, extremes and ties
    send_item(make_cmd(vnsl_pkg::OP_QUERY, 12'hfff, 12'h000));
    send_item(make_cmd(vnsl_pkg::OP_IGNORED, 12'hfff, 12'hfff));
    send_item(make_cmd(vnsl_pkg::OP_CLEAR, 12'h000, 12'h000));
    send_item(make_cmd(vnsl_pkg::OP_QUERY, 12'h000, 12'h000));
    send_item(make_cmd(vnsl_pkg::OP_APPEND, 12'h000, 12'h000));
    send_item(make_cmd(vnsl_pkg::OP_QUERY, 12'h000, 12'h000));
    send_item(make_cmd(vnsl_pkg::OP_QUERY, 12'hfff, 12'hfff));
    send_item(make_cmd(vnsl_pkg::OP_APPEND, 12'hfff, 12'hfff));
    send_item(make_cmd(vnsl_pkg::OP_QUERY, 12'd2047, 12'd2048));
    send_item(make_cmd(vnsl_pkg::OP_QUERY, 12'd2048, 12'd2047));
    send_item(make_cmd(vnsl_pkg::OP_QUERY, 12'hfff, 12'hffe));
    send_item(make_cmd(vnsl_pkg::OP_APPEND, 12'h000, 12'h000));
    send_item(make_cmd(vnsl_pkg::OP_QUERY, 12'h001, 12'h001));
    send_item(make_cmd(vnsl_pkg::OP_IGNORED, 12'h000, 12'h000));
    send_item(make_cmd(vnsl_pkg::OP_QUERY, 12'h000, 12'h000));
    send_item(make_cmd(vnsl_pkg::OP_CLEAR, 12'hfff, 12'hfff));
    send_item(make_cmd(vnsl_pkg::OP_QUERY, 12'h800, 12'h800));
    send_item(make_cmd(vnsl_pkg::OP_APPEND, 12'hfff, 12'h000));
    send_item(make_cmd(vnsl_pkg::OP_QUERY, 12'h000, 12'hfff));
    send_item(make_cmd(vnsl_pkg::OP_QUERY, 12'hfff, 12'h000));
    wait_drained();

    items_sent = 0;
    for (int s = 0; items_sent < RANDOM_ITEMS; s++) begin
      no_idle = (items_sent >= 400 && items_sent < 700);
      run_sequence();
      if (s == 1 || $urandom_range(99) < 5) wait_drained();
    end

    @(negedge clk);
    start <= 1'b0;
    while (label_sb.pending_labels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (label_sb.fail_count == 0) begin
      $display("voronoi_nearest_seed_label_tb OK");
    end else begin
      $display("voronoi_nearest_seed_label_tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/vnsl_pkg.sv
rtl/vnsl_ctrl.sv
rtl/vnsl_dpath.sv
rtl/voronoi_nearest_seed_label.sv
verif/voronoi_nearest_seed_label_tb.sv
